@@ rtl/core/i2crts_pkg.sv @@
package i2crts_pkg;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // Engine status codes, low three bits masked off
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  // Bus actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RACK  = 3'd3;
  localparam logic [2:0] ACT_RNACK = 3'd4;
  localparam logic [2:0] ACT_STOP  = 3'd5;

  // Completion codes; an error reports the phase it failed in
  localparam logic [3:0] RES_OK         = 4'd0;
  localparam logic [3:0] RES_START      = 4'd1;
  localparam logic [3:0] RES_ADDR_W     = 4'd2;
  localparam logic [3:0] RES_REG        = 4'd3;
  localparam logic [3:0] RES_DATA       = 4'd4;
  localparam logic [3:0] RES_REP_START  = 4'd5;
  localparam logic [3:0] RES_ADDR_R     = 4'd6;
  localparam logic [3:0] RES_DATA_ACK   = 4'd7;
  localparam logic [3:0] RES_LAST_NACK  = 4'd8;

  localparam int SLAVE_ADDR_W = 7;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_START  = 9'b000000010,
    PH_SLAW   = 9'b000000100,
    PH_REG    = 9'b000001000,
    PH_DATA   = 9'b000010000,
    PH_RSTART = 9'b000100000,
    PH_SLAR   = 9'b001000000,
    PH_DACK   = 9'b010000000,
    PH_DNACK  = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       is_read;
    logic [7:0] saved_register;
    logic [7:0] saved_data;
    logic [7:0] bytes_left;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [3:0] result_code;
    logic       rejected;
  } out_item_t;

endpackage

@@ rtl/core/i2crts_step.sv @@
module i2crts_step (
  input  i2crts_pkg::seq_state_t                     state,
  input  i2crts_pkg::in_item_t                       item,
  input  logic [i2crts_pkg::SLAVE_ADDR_W-1:0]        dev_addr,
  output i2crts_pkg::seq_state_t                     state_next,
  output i2crts_pkg::out_item_t                      res
);
  import i2crts_pkg::*;

  logic [7:0] st;
  logic       ok;
  logic [7:0] bytes_dec;
  logic [3:0] err_code;

  assign st        = item.bus_status & STATUS_MASK;
  assign bytes_dec = state.bytes_left - 8'd1;

  always_comb begin
    state_next = state;
    res        = '0;
    ok         = 1'b1;
    err_code   = RES_OK;

    if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
      if (state.phase != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        state_next.phase          = PH_START;
        state_next.is_read        = item.cmd[0];
        state_next.saved_register = item.reg_addr;
        state_next.saved_data     = item.write_data;
        // zero length reads one byte
        state_next.bytes_left     = (item.read_length == 8'd0) ? 8'd1 : item.read_length;
        res.bus_action            = ACT_START;
      end
    end else if (item.cmd != CMD_EVENT || state.phase == PH_IDLE) begin
      res.rejected = 1'b1;
    end else begin
      unique case (state.phase)
        PH_START: begin
          ok       = (st == ST_START) || (st == ST_REP_START);
          err_code = RES_START;
          state_next.phase = PH_SLAW;
          res.bus_action   = ACT_SEND;
          res.tx_byte      = {dev_addr, 1'b0};
        end
        PH_SLAW: begin
          ok       = (st == ST_MT_SLA_ACK);
          err_code = RES_ADDR_W;
          state_next.phase = PH_REG;
          res.bus_action   = ACT_SEND;
          res.tx_byte      = state.saved_register;
        end
        PH_REG: begin
          ok       = (st == ST_MT_DATA_ACK);
          err_code = RES_REG;
          if (state.is_read) begin
            state_next.phase = PH_RSTART;
            res.bus_action   = ACT_START;
          end else begin
            state_next.phase = PH_DATA;
            res.bus_action   = ACT_SEND;
            res.tx_byte      = state.saved_data;
          end
        end
        PH_DATA: begin
          ok       = (st == ST_MT_DATA_ACK);
          err_code = RES_DATA;
          state_next.phase = PH_IDLE;
          res.bus_action   = ACT_STOP;
          res.done_res     = 1'b1;
        end
        PH_RSTART: begin
          ok       = (st == ST_REP_START);
          err_code = RES_REP_START;
          state_next.phase = PH_SLAR;
          res.bus_action   = ACT_SEND;
          res.tx_byte      = {dev_addr, 1'b1};
        end
        PH_SLAR: begin
          ok       = (st == ST_MR_SLA_ACK);
          err_code = RES_ADDR_R;
          state_next.phase = (state.bytes_left >= 8'd2) ? PH_DACK : PH_DNACK;
          res.bus_action   = (state.bytes_left >= 8'd2) ? ACT_RACK : ACT_RNACK;
        end
        PH_DACK: begin
          ok       = (st == ST_MR_DATA_ACK);
          err_code = RES_DATA_ACK;
          state_next.bytes_left = bytes_dec;
          state_next.phase = (bytes_dec >= 8'd2) ? PH_DACK : PH_DNACK;
          res.bus_action   = (bytes_dec >= 8'd2) ? ACT_RACK : ACT_RNACK;
          res.read_valid   = 1'b1;
          res.read_byte    = item.rx_byte;
        end
        PH_DNACK: begin
          ok       = (st == ST_MR_DATA_NACK);
          err_code = RES_LAST_NACK;
          state_next.bytes_left = 8'd0;
          state_next.phase = PH_IDLE;
          res.bus_action   = ACT_STOP;
          res.read_valid   = 1'b1;
          res.read_byte    = item.rx_byte;
          res.done_res     = 1'b1;
        end
        default: begin
          // corrupt phase: drop back to idle and refuse
          state_next.phase = PH_IDLE;
          res.rejected     = 1'b1;
        end
      endcase

      if (!ok) begin
        // status mismatch: end without stop, keep everything but the phase
        state_next             = state;
        state_next.phase       = PH_IDLE;
        res                    = '0;
        res.done_res           = 1'b1;
        res.result_code        = err_code;
      end
    end
  end

endmodule

@@ rtl/core/i2c_register_transaction_sequencer.sv @@
// Register write and burst read sequencer for a byte-level I2C bus engine.
// Every input item (a write command, a read command or an engine status
// event) produces exactly one result item giving the next bus action, any
// received byte and, on the last item of a transaction, a done flag with a
// completion code. An item is taken into an input register, evaluated against
// the transaction state in one pass of logic and stored in the result
// register, so a new item is accepted every cycle unless the output stalls.
// The result register lets the next item enter while a finished result is
// still stalled. Write the slave address only while no item is in flight.
module i2c_register_transaction_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  i2crts_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output i2crts_pkg::out_item_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2crts_pkg::SLAVE_ADDR_W-1:0]  cfg_data
);
  import i2crts_pkg::*;

  logic [SLAVE_ADDR_W-1:0] dev_addr;
  seq_state_t              state;
  seq_state_t              state_next;
  logic                    s1_valid;
  in_item_t                s1_item;
  out_item_t               step_res;
  logic                    s1_fire;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  i2crts_step u_step (
    .state         (state),
    .item          (s1_item),
    .dev_addr      (dev_addr),
    .state_next    (state_next),
    .res           (step_res)
  );

  // advance the transaction state only when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_IDLE;
      state.is_read        <= 1'b0;
      state.saved_register <= '0;
      state.saved_data     <= '0;
      state.bytes_left     <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= step_res;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && step_res.done_res) |=> (state.phase == PH_IDLE))
    else $error("transaction end did not return to idle");

  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && step_res.read_valid) |->
      (state.phase == PH_DACK || state.phase == PH_DNACK))
    else $error("read byte outside a receive phase");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("evaluated item not shown on the output");

endmodule

@@ tb/tb_i2c_register_transaction_sequencer.sv @@
`timescale 1ns / 1ps

module tb_i2c_register_transaction_sequencer;
  import i2crts_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SLAVE_ADDR_W-1:0] cfg_data = '0;

  // stimulus and expectation stores
  in_item_t item_queue[$];
  out_item_t expected_steps[$];
  int items_made = 0;
  int fail_count = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 77;
  int idle_cycles = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;

  // sequencer state mirrored by the predictor
  logic [SLAVE_ADDR_W-1:0] slave_addr_cfg = '0;
  phase_t seq_phase = PH_IDLE;
  logic seq_is_read = 1'b0;
  logic [7:0] seq_reg = '0;
  logic [7:0] seq_data = '0;
  logic [7:0] seq_left = '0;

  i2c_register_transaction_sequencer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic out_item_t next_bus_step(input in_item_t it);
    out_item_t r;
    logic [7:0] st;
    logic ok;
    r = '0;
    ok = 1'b1;
    st = it.bus_status & STATUS_MASK;
    if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
      if (seq_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_is_read = (it.cmd == CMD_READ);
        seq_reg = it.reg_addr;
        seq_data = it.write_data;
        seq_left = (it.read_length == 8'd0) ? 8'd1 : it.read_length;
        seq_phase = PH_START;
        r.bus_action = ACT_START;
      end
    end else if (it.cmd == CMD_RSVD || seq_phase == PH_IDLE) begin
      r.rejected = 1'b1;
    end else begin
      case (seq_phase)
        PH_START: if (st == ST_START || st == ST_REP_START) begin
          seq_phase = PH_SLAW;
          r.bus_action = ACT_SEND;
          r.tx_byte = {slave_addr_cfg, 1'b0};
        end else ok = 1'b0;
        PH_SLAW: if (st == ST_MT_SLA_ACK) begin
          seq_phase = PH_REG;
          r.bus_action = ACT_SEND;
          r.tx_byte = seq_reg;
        end else ok = 1'b0;
        PH_REG: if (st == ST_MT_DATA_ACK) begin
          if (seq_is_read) begin
            seq_phase = PH_RSTART;
            r.bus_action = ACT_START;
          end else begin
            seq_phase = PH_DATA;
            r.bus_action = ACT_SEND;
            r.tx_byte = seq_data;
          end
        end else ok = 1'b0;
        PH_DATA: if (st == ST_MT_DATA_ACK) begin
          seq_phase = PH_IDLE;
          r.bus_action = ACT_STOP;
          r.done_res = 1'b1;
        end else ok = 1'b0;
        PH_RSTART: if (st == ST_REP_START) begin
          seq_phase = PH_SLAR;
          r.bus_action = ACT_SEND;
          r.tx_byte = {slave_addr_cfg, 1'b1};
        end else ok = 1'b0;
        PH_SLAR: if (st == ST_MR_SLA_ACK) begin
          seq_phase = (seq_left >= 8'd2) ? PH_DACK : PH_DNACK;
          r.bus_action = (seq_left >= 8'd2) ? ACT_RACK : ACT_RNACK;
        end else ok = 1'b0;
        PH_DACK: if (st == ST_MR_DATA_ACK) begin
          seq_left = seq_left - 8'd1;
          seq_phase = (seq_left >= 8'd2) ? PH_DACK : PH_DNACK;
          r.bus_action = (seq_left >= 8'd2) ? ACT_RACK : ACT_RNACK;
          r.read_valid = 1'b1;
          r.read_byte = it.rx_byte;
        end else ok = 1'b0;
        PH_DNACK: if (st == ST_MR_DATA_NACK) begin
          seq_left = '0;
          seq_phase = PH_IDLE;
          r.bus_action = ACT_STOP;
          r.read_valid = 1'b1;
          r.read_byte = it.rx_byte;
          r.done_res = 1'b1;
        end else ok = 1'b0;
        default: begin
          seq_phase = PH_IDLE;
          r.rejected = 1'b1;
        end
      endcase
      // wrong status: report the phase it failed in, no stop
      if (!ok) begin
        r.done_res = 1'b1;
        case (seq_phase)
          PH_START:  r.result_code = RES_START;
          PH_SLAW:   r.result_code = RES_ADDR_W;
          PH_REG:    r.result_code = RES_REG;
          PH_DATA:   r.result_code = RES_DATA;
          PH_RSTART: r.result_code = RES_REP_START;
          PH_SLAR:   r.result_code = RES_ADDR_R;
          PH_DACK:   r.result_code = RES_DATA_ACK;
          default:   r.result_code = RES_LAST_NACK;
        endcase
        seq_phase = PH_IDLE;
      end
    end
    return r;
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_item(input in_item_t it);
    item_queue.push_back(it);
    items_made++;
  endtask

  task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] reg_addr,
                          input logic [7:0] data, input logic [7:0] len);
    in_item_t it;
    it = rand_item();
    it.cmd = cmd;
    it.reg_addr = reg_addr;
    it.write_data = data;
    it.read_length = len;
    push_item(it);
  endtask

  // status code with random don't-care low bits
  task automatic push_event(input logic [7:0] code, input logic [7:0] rx);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_EVENT;
    it.bus_status = {code[7:3], it.bus_status[2:0]};
    it.rx_byte = rx;
    push_item(it);
  endtask

  task automatic push_refused_cmd();
    in_item_t it;
    int pick;
    it = rand_item();
    pick = $urandom_range(0, 2);
    it.cmd = (pick == 2) ? CMD_RSVD : ((pick == 1) ? CMD_READ : CMD_WRITE);
    push_item(it);
  endtask

  task automatic push_random_transaction();
    logic [7:0] codes[$];
    logic [7:0] len;
    logic [7:0] bad;
    int roll;
    int break_at;
    int n_rx;
    bit rd;
    rd = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 90) len = 8'($urandom_range(0, 6));
    else if (roll < 98) len = 8'($urandom_range(7, 40));
    else len = 8'($urandom_range(41, 80));
    push_cmd(rd ? CMD_READ : CMD_WRITE, 8'($urandom), 8'($urandom), len);
    codes.push_back(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START);
    codes.push_back(ST_MT_SLA_ACK);
    codes.push_back(ST_MT_DATA_ACK);
    if (!rd) begin
      codes.push_back(ST_MT_DATA_ACK);
    end else begin
      codes.push_back(ST_REP_START);
      codes.push_back(ST_MR_SLA_ACK);
      n_rx = (len == 8'd0) ? 1 : int'(len);
      repeat (n_rx - 1) codes.push_back(ST_MR_DATA_ACK);
      codes.push_back(ST_MR_DATA_NACK);
    end
    break_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, codes.size() - 1) : -1;
    for (int i = 0; i < codes.size(); i++) begin
      if ($urandom_range(0, 99) < 4) push_refused_cmd();
      if (i == break_at) begin
        do bad = 8'($urandom) & STATUS_MASK;
        while (bad == codes[i] || (i == 0 && (bad == ST_START || bad == ST_REP_START)));
        push_event(bad, 8'($urandom));
        return;
      end
      push_event(codes[i], 8'($urandom));
    end
  endtask

  task automatic push_random_items(input int count);
    int goal;
    goal = items_made + count;
    while (items_made < goal) begin
      if ($urandom_range(0, 99) < 6) begin
        if ($urandom_range(0, 1)) push_event(8'($urandom), 8'($urandom));
        else push_refused_cmd();
      end else begin
        push_random_transaction();
      end
    end
  endtask

  task automatic drain();
    while (item_queue.size() != 0 || expected_steps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_slave_addr(input logic [SLAVE_ADDR_W-1:0] addr);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slave_addr_cfg = addr;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    in_item_t sent;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        sent = item_queue.pop_front();
        expected_steps.push_back(next_bus_step(sent));
      end
      if (!in_valid || take) begin
        if (item_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= item_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("result item with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          check_field("bus_action", 8'(want.bus_action), 8'(out_data.bus_action));
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
          check_field("read_byte", want.read_byte, out_data.read_byte);
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
          check_field("result_code", 8'(want.result_code), 8'(out_data.result_code));
          check_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (recv_idle_pct == 0 && !long_hold_done) begin
        long_hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** i2c_register_transaction_sequencer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_slave_addr(7'h7F);

    // event while idle, reserved command while idle
    push_event(ST_START, 8'h00);
    push_cmd(CMD_RSVD, 8'h00, 8'h00, 8'h00);
    // write with extreme register and data
    push_cmd(CMD_WRITE, 8'hFF, 8'h00, 8'h00);
    push_event(ST_START, 8'h00);
    push_event(ST_MT_SLA_ACK, 8'h00);
    push_event(ST_MT_DATA_ACK, 8'h00);
    push_event(ST_MT_DATA_ACK, 8'h00);
    // zero-length read, first start answered by repeated start, refused command mid-way
    push_cmd(CMD_READ, 8'h00, 8'hFF, 8'h00);
    push_event(ST_REP_START, 8'h00);
    push_event(ST_MT_SLA_ACK, 8'h00);
    push_event(ST_MT_DATA_ACK, 8'h00);
    push_event(ST_REP_START, 8'h00);
    push_event(ST_MR_SLA_ACK, 8'h00);
    push_cmd(CMD_WRITE, 8'h12, 8'h34, 8'h01);
    push_event(ST_MR_DATA_NACK, 8'hFF);
    // longest read, cut short by a last-byte status while more bytes are due
    push_cmd(CMD_READ, 8'hA5, 8'h5A, 8'hFF);
    push_event(ST_START, 8'h00);
    push_event(ST_MT_SLA_ACK, 8'h00);
    push_event(ST_MT_DATA_ACK, 8'h00);
    push_event(ST_REP_START, 8'h00);
    push_event(ST_MR_SLA_ACK, 8'h00);
    push_event(ST_MR_DATA_ACK, 8'h00);
    push_event(ST_MR_DATA_ACK, 8'hFF);
    push_event(ST_MR_DATA_NACK, 8'h55);
    drain();

    write_slave_addr(7'h00);
    push_random_items(175);
    drain();

    write_slave_addr(SLAVE_ADDR_W'($urandom_range(1, 126)));
    send_idle_pct = 77;
    recv_idle_pct = 22;
    push_random_items(175);
    drain();

    write_slave_addr(SLAVE_ADDR_W'($urandom_range(1, 126)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_items(175);
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** i2c_register_transaction_sequencer: PASSED **");
    end else begin
      $display("** i2c_register_transaction_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
